// File: sv/rxdr_pkg.sv
// Shared types, constants and helpers for the receive descriptor-ring engine.
package rxdr_pkg;

	localparam int MAX_PACKET  = 8192;
	localparam int DESC_STRIDE = 8;
	localparam int LEN_W       = 13;
	localparam int POS_W       = 14;
	localparam int MAX_RES     = 4;

	localparam logic [31:0] OWN_BIT  = 32'h8000_0000;
	localparam logic [31:0] WRAP_BIT = 32'h4000_0000;
	localparam logic [31:0] CONT_BIT = 32'h0800_0000;

	localparam logic [1:0] FN_ARRIVE = 2'd0;
	localparam logic [1:0] FN_DESC   = 2'd1;
	localparam logic [1:0] FN_STATUS = 2'd2;

	localparam logic REG_RING_BASE = 1'b0;
	localparam logic REG_CRC_FOUR  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_DESC   = 2'd1,
		PH_STATUS = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		OP_READ_DESC   = 3'd0,
		OP_READ_STATUS = 3'd1,
		OP_COPY        = 3'd2,
		OP_WRITE_STAT  = 3'd3,
		OP_IRQ         = 3'd4
	} op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] packet_length;
		logic [31:0] descriptor_status;
		logic [31:0] descriptor_buffer;
	} item_t;

	typedef struct packed {
		op_t              op;
		logic [31:0]      address;
		logic [LEN_W-1:0] copy_length;
		logic [POS_W-1:0] packet_offset;
		logic [31:0]      status_value;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [31:0]      cur_desc;
		logic [31:0]      first_desc;
		logic [31:0]      first_stat;
		logic [31:0]      next_desc;
		logic [POS_W-1:0] rem;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] chunk;
		logic             on_first;
		phase_t           phase;
	} state_t;

	function automatic res_t mk_res(op_t op, logic [31:0] addr, logic [LEN_W-1:0] len,
			logic [POS_W-1:0] off, logic [31:0] val);
		res_t r;
		r.op            = op;
		r.address       = addr;
		r.copy_length   = len;
		r.packet_offset = off;
		r.status_value  = val;
		r.last          = 1'b0;
		return r;
	endfunction

endpackage

// File: sv/rxdr_step.sv
// One step of the ring walk: next state and up to four memory commands for one beat.
module rxdr_step (
	input  rxdr_pkg::state_t                   st,
	input  rxdr_pkg::item_t                    it,
	input  logic [31:0]                        ring_base,
	input  logic                               crc_four,
	output rxdr_pkg::state_t                   nst,
	output rxdr_pkg::res_t [rxdr_pkg::MAX_RES-1:0] res,
	output logic [2:0]                         cnt
);
	import rxdr_pkg::*;

	logic [2:0]       k;
	logic             go;
	logic             own;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] cp;
	logic [POS_W-1:0] new_rem;
	logic [31:0]      nxt;
	logic [31:0]      v;

	always_comb begin
		nst     = st;
		k       = 3'd0;
		go      = 1'b0;
		own     = (it.descriptor_status & OWN_BIT) != 32'd0;
		len     = it.descriptor_status[LEN_W-1:0];
		cp      = ({1'b0, len} < st.rem) ? len : st.rem[LEN_W-1:0];
		new_rem = st.rem - {1'b0, cp};
		nxt     = ((it.descriptor_status & WRAP_BIT) != 32'd0) ? ring_base
			: st.cur_desc + 32'(DESC_STRIDE);
		v       = 32'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = mk_res(OP_READ_DESC, 32'd0, '0, '0, 32'd0);
		end

		if (it.func == FN_ARRIVE && st.phase == PH_IDLE) begin
			if (ring_base != 32'd0) begin
				nst.rem      = (it.packet_length > 16'(MAX_PACKET)) ? POS_W'(MAX_PACKET)
					: it.packet_length[POS_W-1:0];
				nst.pos      = '0;
				nst.on_first = 1'b1;
				nst.phase    = PH_DESC;
				res[k[1:0]]  = mk_res(OP_READ_DESC, st.cur_desc, '0, '0, 32'd0);
				k            = k + 3'd1;
			end
		end else if (it.func == FN_DESC && st.phase == PH_DESC) begin
			go = 1'b1;
			if (st.on_first) begin
				if (!own) begin
					nst.phase = PH_IDLE;
					go        = 1'b0;
				end else begin
					nst.first_desc = st.cur_desc;
					nst.first_stat = it.descriptor_status;
					if (st.rem == '0) begin
						// Empty packet: hand the first descriptor back untouched.
						res[k[1:0]] = mk_res(OP_WRITE_STAT, st.cur_desc, '0, '0,
							it.descriptor_status);
						k           = k + 3'd1;
						res[k[1:0]] = mk_res(OP_IRQ, 32'd0, '0, '0, 32'd0);
						k           = k + 3'd1;
						nst.phase   = PH_IDLE;
						go          = 1'b0;
					end
				end
			end
			if (go) begin
				res[k[1:0]] = mk_res(OP_COPY, it.descriptor_buffer, cp, st.pos, 32'd0);
				k           = k + 3'd1;
				nst.pos     = st.pos + {1'b0, cp};
				nst.rem     = new_rem;
				if (new_rem == '0) begin
					v = 32'(cp) + (crc_four ? 32'd4 : 32'd2);
					if (st.on_first) begin
						nst.first_stat = v;
					end else begin
						res[k[1:0]] = mk_res(OP_WRITE_STAT, st.cur_desc, '0, '0, v);
						k           = k + 3'd1;
					end
					nst.cur_desc = nxt;
					res[k[1:0]]  = mk_res(OP_WRITE_STAT, nst.first_desc, '0, '0,
						nst.first_stat);
					k            = k + 3'd1;
					res[k[1:0]]  = mk_res(OP_IRQ, 32'd0, '0, '0, 32'd0);
					k            = k + 3'd1;
					nst.phase    = PH_IDLE;
				end else begin
					nst.chunk     = cp;
					nst.next_desc = nxt;
					nst.phase     = PH_STATUS;
					res[k[1:0]]   = mk_res(OP_READ_STATUS, nxt, '0, '0, 32'd0);
					k             = k + 3'd1;
				end
			end
		end else if (it.func == FN_STATUS && st.phase == PH_STATUS) begin
			v = (own ? CONT_BIT : 32'd0) | 32'(st.chunk);
			if (st.on_first) begin
				nst.first_stat = v;
			end else begin
				res[k[1:0]] = mk_res(OP_WRITE_STAT, st.cur_desc, '0, '0, v);
				k           = k + 3'd1;
			end
			nst.cur_desc = st.next_desc;
			if (own) begin
				nst.on_first = 1'b0;
				nst.phase    = PH_DESC;
				res[k[1:0]]  = mk_res(OP_READ_DESC, st.next_desc, '0, '0, 32'd0);
				k            = k + 3'd1;
			end else begin
				// Next buffer not ours: the rest of the packet is dropped.
				res[k[1:0]] = mk_res(OP_WRITE_STAT, nst.first_desc, '0, '0,
					nst.first_stat);
				k           = k + 3'd1;
				res[k[1:0]] = mk_res(OP_IRQ, 32'd0, '0, '0, 32'd0);
				k           = k + 3'd1;
				nst.phase   = PH_IDLE;
			end
		end

		for (int i = 0; i < MAX_RES; i++) begin
			res[i].last = (k != 3'd0) && (3'(i) == k - 3'd1);
		end
		cnt = k;
	end

endmodule

// File: sv/rx_descriptor_ring_engine.sv
// Receive descriptor-ring engine: walks a DMA ring and issues memory commands per packet.
//
// The slave stream carries packet arrivals (tuser = 0) and the memory responses
// to earlier commands: full descriptors (tuser = 1) and status words (tuser = 2).
// The master stream carries memory commands, kind in tuser: read descriptor, read
// status word, copy data, write status, interrupt. tlast marks the final command
// caused by one input beat; a beat may cause none.
// The cfg port writes ring_base (index 0; zero disables receive and a write also
// reloads the current descriptor pointer) and crc_four (index 1).
// A beat is held in an input register and, once the bank is free, processed into
// a bank of up to four result registers, whose head command is shown to the master.
// The bank drains one command per cycle while the master is ready; a beat causes
// up to four commands, and the next beat is processed in the cycle the bank's last
// command leaves. A stalled master holds the bank and,
// once the input register is full, the slave side.
// Reset returns the walk state to idle and clears both config registers, so receive starts disabled.
module rx_descriptor_ring_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // packet_length, descriptor_status, descriptor_buffer
	input  logic [1:0]  s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // address, copy_length, packet_offset, status_value, pad
	output logic [2:0]  m_axis_tuser,  // op
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import rxdr_pkg::*;

	logic                   s1_valid;
	item_t                  item_s1;
	logic [31:0]            ring_base_q;
	logic                   crc_four_q;
	state_t                 st_q;
	state_t                 st_next;
	res_t [MAX_RES-1:0]     res_q;
	res_t [MAX_RES-1:0]     res_next;
	logic [2:0]             cnt_q;
	logic [2:0]             cnt_next;
	logic                   take;
	logic                   bank_free;
	logic                   proc;

	assign take          = m_axis_tvalid && m_axis_tready;
	assign bank_free     = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_axis_tready);
	assign proc          = s1_valid && bank_free;
	assign s_axis_tready = !s1_valid || proc;

	rxdr_step u_step (
		.st        (st_q),
		.it        (item_s1),
		.ring_base (ring_base_q),
		.crc_four  (crc_four_q),
		.nst       (st_next),
		.res       (res_next),
		.cnt       (cnt_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.func              <= s_axis_tuser;
			item_s1.packet_length     <= s_axis_tdata[15:0];
			item_s1.descriptor_status <= s_axis_tdata[47:16];
			item_s1.descriptor_buffer <= s_axis_tdata[79:48];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_base_q      <= 32'd0;
			crc_four_q       <= 1'b0;
			st_q.cur_desc    <= 32'd0;
			st_q.first_desc  <= 32'd0;
			st_q.first_stat  <= 32'd0;
			st_q.next_desc   <= 32'd0;
			st_q.rem         <= '0;
			st_q.pos         <= '0;
			st_q.chunk       <= '0;
			st_q.on_first    <= 1'b1;
			st_q.phase       <= PH_IDLE;
		end else begin
			if (proc) begin
				st_q <= st_next;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_RING_BASE: begin
						ring_base_q   <= cfg_data;
						st_q.cur_desc <= cfg_data;
					end
					REG_CRC_FOUR: begin
						crc_four_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (proc) begin
			cnt_q <= cnt_next;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// The head of the bank is always the command on the master side.
	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res_next;
		end else if (take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	assign m_axis_tvalid = cnt_q != 3'd0;
	assign m_axis_tuser  = res_q[0].op;
	assign m_axis_tlast  = res_q[0].last;
	assign m_axis_tdata  = {5'd0, res_q[0].status_value, res_q[0].packet_offset,
		res_q[0].copy_length, res_q[0].address};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(MAX_RES))
		else $error("result bank holds more than four commands");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 3'd0) |-> (res_q[0].last == (cnt_q == 3'd1)))
		else $error("tlast does not match the end of the command group");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> s1_valid)
		else $error("accepted beat lost from the input register");

	a_idle_after_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && cnt_next != 3'd0 && res_next[cnt_next[1:0] - 2'd1].op == OP_IRQ)
		|=> (st_q.phase == PH_IDLE))
		else $error("walk still active after an interrupt");

endmodule
